// File: src/flqs_pkg.sv
// ----------------------------------------------------------------------------
// flqs_pkg
// Shared constants and types of the frame luma quality score block.
// ----------------------------------------------------------------------------
`default_nettype none

package flqs_pkg;

  // Frame capacity in pixels
  localparam longint unsigned MAX_PIXELS = 65536;

  // Accumulator widths, sized for a full frame
  localparam int unsigned CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned LUMA_W = 8;
  localparam int unsigned SUM_W  = $clog2(MAX_PIXELS * 255 + 1);
  localparam int unsigned SQ_W   = $clog2(MAX_PIXELS * 65025 + 1);

  // Back end arithmetic widths
  localparam int unsigned A_W     = SQ_W + 1;        // sq_sum + 2*sum + 2500*(N-dark)
  localparam int unsigned LO_W    = CNT_W;           // low slice of the A*N product
  localparam int unsigned HI_W    = A_W - LO_W;      // high slice of the A*N product
  localparam int unsigned ACC_W   = 2 * SUM_W + 2;   // A*N - sum^2
  localparam int unsigned NN_W    = 2 * CNT_W;       // N^2 and division remainder
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned SCORE_W = 24;
  localparam int unsigned STEP_W  = $clog2(SCORE_W);

  // Luma weights and thresholds
  localparam int unsigned COEF_R      = 54;
  localparam int unsigned COEF_G      = 183;
  localparam int unsigned COEF_B      = 19;
  localparam int unsigned DARK_LIMIT  = 18;
  localparam int unsigned DARK_WEIGHT = 2500;
  localparam int unsigned MEAN_LIMIT  = 10;

  // Score offsets in 8-bit fixed point
  localparam int unsigned DARK_OFFSET  = DARK_WEIGHT << FRAC_W;  // undoes the bias in A
  localparam int unsigned MEAN_PENALTY = 5000 << FRAC_W;

  // Frame queue depth
  localparam int unsigned FIFO_DEPTH = 2;

  // Totals of one finished frame, handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0] pix_cnt;
    logic [SUM_W-1:0] luma_sum;
    logic [SQ_W-1:0]  sq_sum;
    logic [CNT_W-1:0] dark_cnt;
    logic             overflow;
  } frame_t;

endpackage

`default_nettype wire

// File: src/flqs_front.sv
// ----------------------------------------------------------------------------
// flqs_front
// Pixel front end: luma per pixel, frame totals, hand-off of finished frames.
// ----------------------------------------------------------------------------
`default_nettype none

module flqs_front import flqs_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                pix_valid_i,
  output      logic                pix_ready_o,
  input  wire logic [LUMA_W-1:0]   red_i,
  input  wire logic [LUMA_W-1:0]   green_i,
  input  wire logic [LUMA_W-1:0]   blue_i,
  input  wire logic                last_i,
  input  wire logic                fifo_full_i,
  output      logic                push_o,
  output      frame_t              push_frame_o
);

  logic              vld_q;
  logic [LUMA_W-1:0] luma_q;
  logic              last_q;
  logic [15:0]       wsum;
  logic              advance;

  logic [CNT_W-1:0]  pix_cnt_q, pix_cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [CNT_W-1:0]  dark_q, dark_d;
  logic              ovf_q, ovf_d;

  // Weighted channel sum, luma is its upper byte
  assign wsum = 16'(16'(COEF_R) * 16'(red_i) + 16'(COEF_G) * 16'(green_i)
                    + 16'(COEF_B) * 16'(blue_i));

  // Stage moves unless a frame end waits on a full queue
  assign advance     = vld_q && !(last_q && fifo_full_i);
  assign pix_ready_o = !vld_q || advance;

  // Luma stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pix_ready_o) begin
      vld_q <= pix_valid_i;
    end
  end

  // Luma stage payload
  always_ff @(posedge clk_i) begin
    if (pix_ready_o && pix_valid_i) begin
      luma_q <= wsum[15:8];
      last_q <= last_i;
    end
  end

  // Frame totals including the current pixel
  always_comb begin
    pix_cnt_d = pix_cnt_q;
    sum_d     = sum_q;
    sq_d      = sq_q;
    dark_d    = dark_q;
    ovf_d     = ovf_q;
    if (pix_cnt_q == CNT_W'(MAX_PIXELS)) begin
      ovf_d = 1'b1;
    end else begin
      pix_cnt_d = pix_cnt_q + 1'b1;
      sum_d     = sum_q + SUM_W'(luma_q);
      sq_d      = sq_q + SQ_W'(16'(luma_q) * 16'(luma_q));
      if (luma_q < LUMA_W'(DARK_LIMIT)) begin
        dark_d = dark_q + 1'b1;
      end
    end
  end

  // Hand off on the last pixel
  assign push_o                = vld_q && last_q && !fifo_full_i;
  assign push_frame_o.pix_cnt  = pix_cnt_d;
  assign push_frame_o.luma_sum = sum_d;
  assign push_frame_o.sq_sum   = sq_d;
  assign push_frame_o.dark_cnt = dark_d;
  assign push_frame_o.overflow = ovf_d;

  // Accumulators, cleared at each frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_cnt_q <= '0;
      sum_q     <= '0;
      sq_q      <= '0;
      dark_q    <= '0;
      ovf_q     <= 1'b0;
    end else if (advance) begin
      if (last_q) begin
        pix_cnt_q <= '0;
        sum_q     <= '0;
        sq_q      <= '0;
        dark_q    <= '0;
        ovf_q     <= 1'b0;
      end else begin
        pix_cnt_q <= pix_cnt_d;
        sum_q     <= sum_d;
        sq_q      <= sq_d;
        dark_q    <= dark_d;
        ovf_q     <= ovf_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/flqs_fifo.sv
// ----------------------------------------------------------------------------
// flqs_fifo
// Short queue of finished frame totals between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module flqs_fifo import flqs_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire frame_t data_i,
  output      logic   full_o,
  input  wire logic   pop_i,
  output      logic   valid_o,
  output      frame_t data_o
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W = $clog2(FIFO_DEPTH + 1);

  frame_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FCNT_W-1:0]  count_q;

  assign full_o  = (count_q == FCNT_W'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("frame pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("frame popped from empty queue");

  a_fill_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill level lost a push");

endmodule

`default_nettype wire

// File: src/flqs_back.sv
// ----------------------------------------------------------------------------
// flqs_back
// Score back end: products in steps, radix-2 division, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flqs_back import flqs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fifo_valid_i,
  input  wire frame_t             fifo_frame_i,
  output      logic               pop_o,
  output      logic               res_valid_o,
  input  wire logic               res_ready_i,
  output      logic [SCORE_W-1:0] res_score_o,
  output      logic               res_ovf_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_NSQ,
    ST_PLO,
    ST_PHI,
    ST_DINIT,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q;
  frame_t              frm_q;
  logic [2*SUM_W-1:0]  sq_q;
  logic [A_W-1:0]      a_q;
  logic                pen_q;
  logic [NN_W-1:0]     nn_q;
  logic [ACC_W-1:0]    acc_q;
  logic [NN_W-1:0]     rem_q;
  logic [SCORE_W-1:0]  quo_q;
  logic [STEP_W-1:0]   step_q;

  logic                res_valid_q;
  logic [SCORE_W-1:0]  res_score_q;
  logic                res_ovf_q;

  logic [NN_W:0]       trial;
  logic                qbit;
  logic [SCORE_W-1:0]  score;

  assign pop_o = (state_q == ST_IDLE) && fifo_valid_i;

  // One division step: shift in next numerator bit, subtract if it fits
  assign trial = {rem_q, quo_q[SCORE_W-1]};
  assign qbit  = (trial >= {1'b0, nn_q});

  // Remove the dark bias, apply the low-mean penalty, give zero for an empty frame
  always_comb begin
    score = quo_q - SCORE_W'(DARK_OFFSET);
    if (pen_q) begin
      score = score - SCORE_W'(MEAN_PENALTY);
    end
    if (frm_q.pix_cnt == '0) begin
      score = '0;
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      res_valid_q <= 1'b0;
      res_score_q <= '0;
      res_ovf_q   <= 1'b0;
    end else begin
      // Result taken; a new one loaded in ST_DONE takes its place instead
      if (res_valid_q && res_ready_i && (state_q != ST_DONE)) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (fifo_valid_i) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP:  state_q <= ST_NSQ;
        ST_NSQ:   state_q <= ST_PLO;
        ST_PLO:   state_q <= ST_PHI;
        ST_PHI:   state_q <= ST_DINIT;
        ST_DINIT: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + 1'b1;
          if (step_q == STEP_W'(SCORE_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_valid_q || res_ready_i) begin
            res_valid_q <= 1'b1;
            res_score_q <= score;
            res_ovf_q   <= frm_q.overflow;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath: A*N - sum^2 and its quotient by N^2
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (fifo_valid_i) begin
          frm_q <= fifo_frame_i;
        end
      end
      ST_PREP: begin
        sq_q  <= (2*SUM_W)'(frm_q.luma_sum) * (2*SUM_W)'(frm_q.luma_sum);
        a_q   <= A_W'(frm_q.sq_sum) + A_W'({frm_q.luma_sum, 1'b0})
                 + A_W'(DARK_WEIGHT) * A_W'(frm_q.pix_cnt - frm_q.dark_cnt);
        pen_q <= ((SUM_W+4)'(frm_q.luma_sum)
                  < (SUM_W+4)'(frm_q.pix_cnt) * (SUM_W+4)'(MEAN_LIMIT));
      end
      ST_NSQ: begin
        nn_q <= NN_W'(frm_q.pix_cnt) * NN_W'(frm_q.pix_cnt);
      end
      ST_PLO: begin
        acc_q <= ACC_W'(a_q[LO_W-1:0]) * ACC_W'(frm_q.pix_cnt) - ACC_W'(sq_q);
      end
      ST_PHI: begin
        acc_q <= acc_q
                 + ((ACC_W'(a_q[A_W-1:LO_W]) * ACC_W'(frm_q.pix_cnt)) << HI_W'(LO_W));
      end
      ST_DINIT: begin
        // Numerator is acc*256; its top part is below N^2
        rem_q <= NN_W'(acc_q >> (SCORE_W - FRAC_W));
        quo_q <= {acc_q[SCORE_W-FRAC_W-1:0], {FRAC_W{1'b0}}};
      end
      ST_DIV: begin
        rem_q <= qbit ? NN_W'(trial - {1'b0, nn_q}) : NN_W'(trial);
        quo_q <= {quo_q[SCORE_W-2:0], qbit};
      end
      default: begin
      end
    endcase
  end

  assign res_valid_o = res_valid_q;
  assign res_score_o = res_score_q;
  assign res_ovf_o   = res_ovf_q;

endmodule

`default_nettype wire

// File: src/frame_luma_quality_score.sv
// ----------------------------------------------------------------------------
// frame_luma_quality_score
// Per-frame luma statistics and quality score over an RGB pixel stream.
// ----------------------------------------------------------------------------
//  Channel  Dir  tdata (low bit up)              tlast       tuser
//  s_axis   in   red[7:0] green[7:0] blue[7:0]   last_pixel  -
//  m_axis   out  score[23:0] (signed, 8 frac)    -           too_many_pixels
//
//  Pixels are taken one per cycle while s_axis_tready is high; luma and totals run in a two-stage front.
//  A frame's score is worked out by the four multiply steps and the 24-step
//  radix-2 divider of the back end, and held until m_axis takes it.
//  Up to two finished frames wait in the queue while the back end works.
//  s_axis_tready drops only while a last pixel waits on a full queue.
//  Reset clears all totals and the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_luma_quality_score import flqs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic        s_axis_tlast,   // last_pixel
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // score[23:0]
  output      logic        m_axis_tuser    // too_many_pixels
);

  logic   push;
  frame_t push_frame;
  logic   fifo_full;
  logic   pop;
  logic   fifo_valid;
  frame_t fifo_frame;

  // Pixel front end
  flqs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_valid_i  (s_axis_tvalid),
    .pix_ready_o  (s_axis_tready),
    .red_i        (s_axis_tdata[7:0]),
    .green_i      (s_axis_tdata[15:8]),
    .blue_i       (s_axis_tdata[23:16]),
    .last_i       (s_axis_tlast),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  // Finished frames
  flqs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_frame),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_frame)
  );

  // Score back end
  flqs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fifo_valid),
    .fifo_frame_i (fifo_frame),
    .pop_o        (pop),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_score_o  (m_axis_tdata),
    .res_ovf_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire
